FILE: hdl/sik_pkg.sv
// Shared constants for the shift-invariant kernel block.
// No dependencies; the interface, top level and checker refer to it by scoped names.
package sik_pkg;

   localparam int MAX_LEN_DEF      = 1024;
   localparam int SAMPLE_WIDTH_DEF = 16;

   localparam logic [1:0] MODE_LOAD_X  = 2'd0;
   localparam logic [1:0] MODE_LOAD_Y  = 2'd1;
   localparam logic [1:0] MODE_COMPUTE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   localparam logic REG_GAMMA = 1'b0;
   localparam logic [15:0] GAMMA_RESET = 16'd256;

   // log2(e) and ln(2), both Q30
   localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
   localparam logic [29:0]        LN2_Q30   = 30'd744261118;
   localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;

   localparam logic [3:0]         TAYLOR_LAST = 4'd12;
   localparam logic signed [11:0] EXP_SAT_N   = 12'sd16;
   localparam logic signed [11:0] EXP_BASE_N  = 12'sd14;

   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage

FILE: hdl/sik_if.sv
// Handshake channels of the shift-invariant kernel block.
// Depends on sik_pkg for default widths.
interface sik_req_if #(parameter int SAMPLE_WIDTH = sik_pkg::SAMPLE_WIDTH_DEF);
   logic                           valid;
   logic                           ready;
   logic [1:0]                     mode;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   modport source (output valid, mode, sample, input ready);
   modport sink   (input valid, mode, sample, output ready);
endinterface

interface sik_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] kernel_value;
   logic [1:0]  status;
   modport source (output valid, kernel_value, status, input ready);
   modport sink   (input valid, kernel_value, status, output ready);
endinterface

FILE: hdl/sik_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Standalone; used by the kernel top level for the series norms.
module sik_isqrt #(
   parameter int IN_W = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [IN_W-1:0]     val,
   output logic                done,
   output logic [IN_W/2-1:0]   root
);
   localparam int ROOT_W = IN_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [IN_W-1:0]   val_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;

   assign rem_sh = {rem_ff[REM_W-3:0], val_ff[IN_W-1:IN_W-2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            val_ff  <= val;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= CNT_W'(ROOT_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            val_ff <= {val_ff[IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

FILE: hdl/sik_div.sv
// Restoring divider, one quotient bit per cycle, numerator taken MSB first.
// Standalone; shared by the correlation scaling and the Taylor series.
module sik_div #(
   parameter int NUM_W = 74,
   parameter int DEN_W = 56,
   parameter int STP_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic [STP_W-1:0] steps,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [STP_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0] rem_sh;
   logic           fits;

   assign rem_sh = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            rem_ff <= fits ? rem_sh - {1'b0, den_ff} : rem_sh;
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

FILE: hdl/shift_invariant_kernel_unit.sv
// Shift-invariant kernel top level: sample stores, sequencer, MAC and exp datapath.
// Depends on sik_pkg, sik_if, sik_isqrt and sik_div.
//
// Usage: beats on req_bus load series x (mode 0) and y (mode 1) while idle,
// one per cycle, up to MAX_LEN each; extra loads are dropped. A mode 2 beat
// computes the sum of exp(gamma*ncc[k]) over all lags and returns one beat on
// rsp_bus, then clears both series. Mode 3 is dropped. gamma is written over the
// csr_ APB port. A compute beat holds req_bus.ready low through the two norm
// square roots, one MAC pass over y per lag, and one shared bit-serial divider
// for the scaling and the twelve Taylor terms of the exponential. An empty
// series or zero norm answers with status 1.
// The result sits in an output register held while rsp_bus stalls; a new result
// waits until the old one is taken. Reset empties both series, drops any
// pending result and sets gamma to 1.0.
module shift_invariant_kernel_unit #(
   parameter int MAX_LEN      = sik_pkg::MAX_LEN_DEF,
   parameter int SAMPLE_WIDTH = sik_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sik_req_if.sink     req_bus,
   sik_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int CW     = $clog2(MAX_LEN + 1);
   localparam int AW     = $clog2(MAX_LEN);
   localparam int NRM_W  = 31 + $clog2(MAX_LEN);
   localparam int SQ_W   = ((NRM_W + 17) / 2) * 2;
   localparam int ROOT_W = SQ_W / 2;
   localparam int P_W    = 2 * ROOT_W;
   localparam int ACC_W  = 32 + $clog2(MAX_LEN);
   localparam int NUM_W  = ACC_W + 32;
   localparam int STP_W  = $clog2(NUM_W + 1);
   localparam int KW     = CW + 1;
   localparam int XI_W   = CW + 2;
   localparam int TOT_W  = 33 + $clog2(2 * MAX_LEN);
   localparam int TERM_W = 31;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_PMUL, ST_LAG, ST_MAC, ST_DIVQ, ST_GMUL,
      ST_ZMUL, ST_WMUL, ST_TMUL, ST_TDIV, ST_EXPF, ST_FIN
   } state_type;

   state_type state_ff;

   logic [15:0]             gamma_ff;
   logic [CW-1:0]           x_cnt_ff, y_cnt_ff, m_ff, n_ff;
   logic [NRM_W-1:0]        nx_ff, ny_ff;
   logic                    sq_start_ff, sq_sel_ff;
   logic [ROOT_W-1:0]       px_ff, py_ff;
   logic [P_W-1:0]          p_ff;
   logic signed [KW-1:0]    lag_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    rd_vld_ff;
   logic signed [15:0]      x_rd_ff, y_rd_ff;
   logic                    dv_start_ff, dv_sel_ff;
   logic [32:0]             q_ff;
   logic signed [25:0]      a_ff;
   logic signed [57:0]      zp_ff;
   logic signed [11:0]      n_exp_ff;
   logic [29:0]             w_ff;
   logic [TERM_W-1:0]       term_ff, tp_ff;
   logic [31:0]             sum_ff;
   logic [3:0]              tk_ff;
   logic [TOT_W-1:0]        total_ff;
   logic                    sat_ff, empty_ff;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_kv_ff;
   logic [1:0]              rsp_st_ff;

   logic [15:0] x_mem [MAX_LEN];
   logic [15:0] y_mem [MAX_LEN];

   // ---- input conversion to Q1.15 ----
   logic signed [15:0] s_q15;
   logic signed [31:0] s_sq;
   generate
      if (SAMPLE_WIDTH >= 16) begin : g_narrow
         assign s_q15 = 16'(req_bus.sample >>> (SAMPLE_WIDTH - 16));
      end else begin : g_widen
         assign s_q15 = {req_bus.sample, {(16 - SAMPLE_WIDTH){1'b0}}};
      end
   endgenerate
   assign s_sq = s_q15 * s_q15;

   logic req_fire, x_we, y_we;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign x_we = req_fire && req_bus.mode == sik_pkg::MODE_LOAD_X && x_cnt_ff < CW'(MAX_LEN);
   assign y_we = req_fire && req_bus.mode == sik_pkg::MODE_LOAD_Y && y_cnt_ff < CW'(MAX_LEN);

   // ---- MAC addressing ----
   logic signed [XI_W-1:0] xi;
   logic                   iss_vld;
   assign xi      = $signed({2'b00, n_ff}) + XI_W'(lag_ff);
   assign iss_vld = (state_ff == ST_MAC) && (n_ff < y_cnt_ff) && !xi[XI_W-1]
                    && (xi < $signed({2'b00, x_cnt_ff}));

   always_ff @(posedge clock) begin
      if (x_we) x_mem[x_cnt_ff[AW-1:0]] <= s_q15;
      if (y_we) y_mem[y_cnt_ff[AW-1:0]] <= s_q15;
      x_rd_ff <= x_mem[xi[AW-1:0]];
      y_rd_ff <= y_mem[n_ff[AW-1:0]];
   end

   // ---- shared units ----
   logic [SQ_W-1:0]   sq_val;
   logic              sq_done;
   logic [ROOT_W-1:0] sq_root;
   assign sq_val = SQ_W'({sq_sel_ff ? ny_ff : nx_ff, 16'h0000});

   sik_isqrt #(.IN_W(SQ_W)) u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start_ff), .val(sq_val),
      .done(sq_done), .root(sq_root)
   );

   logic [ACC_W-1:0] mag;
   logic [NUM_W-1:0] dv_num, dv_quo;
   logic [P_W-1:0]   dv_den;
   logic [STP_W-1:0] dv_steps;
   logic             dv_done;
   assign mag      = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign dv_num   = dv_sel_ff ? {tp_ff, {(NUM_W - TERM_W){1'b0}}} : {mag, 32'h0};
   assign dv_den   = dv_sel_ff ? P_W'(tk_ff) : p_ff;
   assign dv_steps = dv_sel_ff ? STP_W'(TERM_W) : STP_W'(NUM_W);

   sik_div #(.NUM_W(NUM_W), .DEN_W(P_W), .STP_W(STP_W)) u_div (
      .clock(clock), .reset(reset), .start(dv_start_ff), .num(dv_num), .den(dv_den),
      .steps(dv_steps), .done(dv_done), .quo(dv_quo)
   );

   // ---- datapath helpers ----
   logic [48:0]        gprod;
   logic [24:0]        g_mag;
   logic [45:0]        wprod;
   logic [60:0]        tprod;
   logic [TERM_W-1:0]  tq;
   logic [32:0]        e_val;
   logic signed [12:0] rs;
   logic               e_sat;
   logic [CW-1:0]      m_next;

   assign gprod  = 49'(gamma_ff) * 49'(q_ff);
   assign g_mag  = gprod[48:24];
   assign wprod  = 46'(zp_ff[45:30]) * 46'(sik_pkg::LN2_Q30);
   assign tprod  = 61'(term_ff) * 61'(w_ff);
   assign tq     = dv_quo[TERM_W-1:0];
   assign m_next = (x_cnt_ff > y_cnt_ff) ? x_cnt_ff : y_cnt_ff;
   assign rs     = 13'(sik_pkg::EXP_BASE_N) - 13'(n_exp_ff);
   assign e_sat  = n_exp_ff >= sik_pkg::EXP_SAT_N;

   always_comb begin
      if (rs <= 0)
         e_val = rs[0] ? (33'(sum_ff) << 1) : 33'(sum_ff);
      else if (rs >= 13'sd32)
         e_val = '0;
      else
         e_val = 33'(sum_ff >> rs[4:0]);
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gamma_ff     <= sik_pkg::GAMMA_RESET;
         x_cnt_ff     <= '0;
         y_cnt_ff     <= '0;
         nx_ff        <= '0;
         ny_ff        <= '0;
         sq_start_ff  <= 1'b0;
         dv_start_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_start_ff <= 1'b0;
         dv_start_ff <= 1'b0;
         rd_vld_ff   <= iss_vld;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == sik_pkg::REG_GAMMA)
            gamma_ff <= csr_pwdata[15:0];
         // ST_FIN loads the next beat itself
         if (rsp_valid_ff && rsp_bus.ready && state_ff != ST_FIN)
            rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (x_we) begin
                  x_cnt_ff <= x_cnt_ff + 1'b1;
                  nx_ff    <= nx_ff + NRM_W'(unsigned'(s_sq));
               end
               if (y_we) begin
                  y_cnt_ff <= y_cnt_ff + 1'b1;
                  ny_ff    <= ny_ff + NRM_W'(unsigned'(s_sq));
               end
               if (req_fire && req_bus.mode == sik_pkg::MODE_COMPUTE) begin
                  m_ff <= m_next;
                  if (x_cnt_ff == '0 || y_cnt_ff == '0 || nx_ff == '0 || ny_ff == '0) begin
                     empty_ff <= 1'b1;
                     state_ff <= ST_FIN;
                  end else begin
                     empty_ff    <= 1'b0;
                     sq_sel_ff   <= 1'b0;
                     sq_start_ff <= 1'b1;
                     state_ff    <= ST_SQX;
                  end
               end
            end
            ST_SQX: begin
               if (sq_done) begin
                  px_ff       <= sq_root;
                  sq_sel_ff   <= 1'b1;
                  sq_start_ff <= 1'b1;
                  state_ff    <= ST_SQY;
               end
            end
            ST_SQY: begin
               if (sq_done) begin
                  py_ff    <= sq_root;
                  state_ff <= ST_PMUL;
               end
            end
            ST_PMUL: begin
               p_ff     <= P_W'(px_ff) * P_W'(py_ff);
               lag_ff   <= -$signed({1'b0, CW'(m_ff - 1'b1)});
               total_ff <= '0;
               sat_ff   <= 1'b0;
               state_ff <= ST_LAG;
            end
            ST_LAG: begin
               acc_ff   <= '0;
               n_ff     <= '0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               // read data arrives the cycle after its address is issued
               if (rd_vld_ff)
                  acc_ff <= acc_ff + ACC_W'(x_rd_ff) * ACC_W'(y_rd_ff);
               if (n_ff < y_cnt_ff) begin
                  n_ff <= n_ff + 1'b1;
               end else begin
                  dv_sel_ff   <= 1'b0;
                  dv_start_ff <= 1'b1;
                  state_ff    <= ST_DIVQ;
               end
            end
            ST_DIVQ: begin
               if (dv_done) begin
                  q_ff     <= (dv_quo > NUM_W'(33'h1_0000_0000)) ? 33'h1_0000_0000
                                                                 : dv_quo[32:0];
                  state_ff <= ST_GMUL;
               end
            end
            ST_GMUL: begin
               a_ff     <= acc_ff[ACC_W-1] ? -$signed({1'b0, g_mag}) : $signed({1'b0, g_mag});
               state_ff <= ST_ZMUL;
            end
            ST_ZMUL: begin
               zp_ff    <= 58'(a_ff) * 58'(sik_pkg::LOG2E_Q30);
               state_ff <= ST_WMUL;
            end
            ST_WMUL: begin
               // z = zp >>> 30; integer part z >>> 16, fraction z[15:0]
               n_exp_ff <= zp_ff[57:46];
               w_ff     <= wprod[45:16];
               term_ff  <= sik_pkg::ONE_Q30;
               sum_ff   <= 32'(sik_pkg::ONE_Q30);
               tk_ff    <= 4'd1;
               state_ff <= ST_TMUL;
            end
            ST_TMUL: begin
               tp_ff       <= tprod[60:30];
               dv_sel_ff   <= 1'b1;
               dv_start_ff <= 1'b1;
               state_ff    <= ST_TDIV;
            end
            ST_TDIV: begin
               if (dv_done) begin
                  term_ff <= tq;
                  sum_ff  <= sum_ff + 32'(tq);
                  if (tk_ff == sik_pkg::TAYLOR_LAST) begin
                     state_ff <= ST_EXPF;
                  end else begin
                     tk_ff    <= tk_ff + 1'b1;
                     state_ff <= ST_TMUL;
                  end
               end
            end
            ST_EXPF: begin
               if (e_sat) sat_ff <= 1'b1;
               else       total_ff <= total_ff + TOT_W'(e_val);
               if (lag_ff == $signed({1'b0, CW'(m_ff - 1'b1)})) begin
                  state_ff <= ST_FIN;
               end else begin
                  lag_ff   <= lag_ff + 1'b1;
                  state_ff <= ST_LAG;
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  if (empty_ff) begin
                     rsp_kv_ff <= '0;
                     rsp_st_ff <= sik_pkg::STATUS_EMPTY;
                  end else if (sat_ff || total_ff > TOT_W'(sik_pkg::SAT32)) begin
                     rsp_kv_ff <= sik_pkg::SAT32;
                     rsp_st_ff <= sik_pkg::STATUS_SAT;
                  end else begin
                     rsp_kv_ff <= total_ff[31:0];
                     rsp_st_ff <= sik_pkg::STATUS_OK;
                  end
                  x_cnt_ff <= '0;
                  y_cnt_ff <= '0;
                  nx_ff    <= '0;
                  ny_ff    <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kernel_value = rsp_kv_ff;
   assign rsp_bus.status       = rsp_st_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == sik_pkg::REG_GAMMA) ? {16'h0000, gamma_ff} : 32'h0;
endmodule

FILE: hdl/sik_checker.sv
// Port-level checks for the shift-invariant kernel block, bound to the top level.
// Depends on sik_pkg and shift_invariant_kernel_unit.
module sik_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] kernel_value,
   input logic [1:0]  status
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat survived reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kernel_value) && $stable(status))
      else $error("stalled result beat changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == sik_pkg::STATUS_EMPTY |-> kernel_value == 32'h0)
      else $error("empty status with nonzero value");

   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == sik_pkg::STATUS_SAT |-> kernel_value == sik_pkg::SAT32)
      else $error("saturated status without full-scale value");

   a_busy_before_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result beat appeared while input was open");
endmodule

bind shift_invariant_kernel_unit sik_checker u_sik_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .kernel_value(rsp_bus.kernel_value),
   .status(rsp_bus.status)
);
